[design/message_rate_and_byte_window_throttle_core_assert.svh]
// Assertion macros shared by the throttle RTL.
`ifndef MESSAGE_RATE_AND_BYTE_WINDOW_THROTTLE_CORE_ASSERT_SVH
`define MESSAGE_RATE_AND_BYTE_WINDOW_THROTTLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MRBWT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define MRBWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mrbwt_pkg.sv]
// Package: widths, ring geometry and register indexes of the throttle.
package mrbwt_pkg;

  // Ring depth must be a power of two so ring indexes wrap naturally.
  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = IDX_W + 1;

  localparam int TIME_W  = 48;
  localparam int LEN_W   = 32;
  localparam int SUM_W   = 33;
  localparam int ENTRY_W = TIME_W + LEN_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = CFG_IDX_W'(3);

  localparam logic [TIME_W-1:0] WINDOW_TICKS_RESET = TIME_W'(1000000);

endpackage

[design/message_rate_and_byte_window_throttle_core.sv]
// Top level: message-period / sliding-window byte admission throttle.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | now_ticks_i, message_bytes_i
//  out     | output    | out_valid_o / out_stall_i | pass_o, ring_full_drop_o,
//          |           |                           | bytes_in_window_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Message mode: each item steps through accept, clamp and period compare.
// Byte mode: accept, check, one expiry step per entry retired, plus one when a live
// entry stops the walk, then decide; the ring memory read is registered.
// Reset clears counters, sums and times; ring contents need no clearing pass.
// A result waiting under out_stall_i holds the last state; the next item is
// still taken and runs until its own result must be written.
`include "message_rate_and_byte_window_throttle_core_assert.svh"

module message_rate_and_byte_window_throttle_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mrbwt_pkg::TIME_W-1:0]      now_ticks_i,
  input  logic [mrbwt_pkg::LEN_W-1:0]       message_bytes_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              pass_o,
  output logic                              ring_full_drop_o,
  output logic [mrbwt_pkg::SUM_W-1:0]       bytes_in_window_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mrbwt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mrbwt_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int TIME_W  = mrbwt_pkg::TIME_W;
  localparam int LEN_W   = mrbwt_pkg::LEN_W;
  localparam int SUM_W   = mrbwt_pkg::SUM_W;
  localparam int IDX_W   = mrbwt_pkg::IDX_W;
  localparam int CNT_W   = mrbwt_pkg::CNT_W;
  localparam int ENTRY_W = mrbwt_pkg::ENTRY_W;

  localparam logic [CNT_W-1:0] RING_FULL = CNT_W'(mrbwt_pkg::RING_DEPTH);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_MSG    = 3'd2;
  localparam logic [2:0] S_EXP    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0]        state_q, state_d;

  // Configuration registers
  logic              mode_q;
  logic [TIME_W-1:0] min_period_q;
  logic [LEN_W-1:0]  byte_limit_q;
  logic [TIME_W-1:0] window_q;

  // Throttle state
  logic [TIME_W-1:0] last_pass_q, last_pass_d;
  logic [IDX_W-1:0]  oldest_q, oldest_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  sum_q, sum_d;

  // Captured item
  logic [TIME_W-1:0] now_q;
  logic [LEN_W-1:0]  len_q;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic              pass_q, pass_d;
  logic              full_q, full_d;
  logic [SUM_W-1:0]  bytes_q, bytes_d;

  // Ring memory: {time, length} per entry
  logic [ENTRY_W-1:0] ring_mem [mrbwt_pkg::RING_DEPTH];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr, wr_addr;

  logic               in_accept, out_take, out_free;
  logic [TIME_W-1:0]  rd_time;
  logic [LEN_W-1:0]   rd_len;
  logic               expire;
  logic               below_limit;
  logic [TIME_W-1:0]  elapsed;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  assign rd_time = rd_data_q[ENTRY_W-1:LEN_W];
  assign rd_len  = rd_data_q[LEN_W-1:0];

  // Entry retires when its time plus the window lies strictly before now.
  assign expire = ({1'b0, rd_time} + {1'b0, window_q}) < {1'b0, now_q};

  assign below_limit = sum_q < {1'b0, byte_limit_q};
  assign elapsed     = now_q - last_pass_q;

  // Read at the head of the ring; during the expiry walk, prefetch the next head.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = oldest_q;
    if (state_q == S_CHECK) begin
      rd_en = 1'b1;
    end else if (state_q == S_EXP) begin
      rd_en   = 1'b1;
      rd_addr = oldest_q + IDX_W'(1);
    end
  end

  assign wr_addr = oldest_q + cnt_q[IDX_W-1:0];

  // Sequencer and read-modify-write of the ring bookkeeping
  always_comb begin
    state_d     = state_q;
    last_pass_d = last_pass_q;
    oldest_d    = oldest_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    out_valid_d = out_take ? 1'b0 : out_valid_q;
    pass_d      = pass_q;
    full_d      = full_q;
    bytes_d     = bytes_q;
    wr_en       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (mode_q) begin
          // time went backwards: pull the stored pass time back
          if (last_pass_q > now_q) begin
            last_pass_d = now_q;
          end
          state_d = S_MSG;
        end else if (cnt_q == '0) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_EXP;
        end
      end
      S_MSG: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          pass_d      = elapsed > min_period_q;
          full_d      = 1'b0;
          bytes_d     = '0;
          if (elapsed > min_period_q) begin
            last_pass_d = now_q;
          end
          state_d = S_IDLE;
        end
      end
      S_EXP: begin
        if (expire) begin
          sum_d    = sum_q - {1'b0, rd_len};
          oldest_d = oldest_q + IDX_W'(1);
          cnt_d    = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_d = S_DECIDE;
          end
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          bytes_d     = sum_q;
          pass_d      = 1'b0;
          full_d      = 1'b0;
          if (below_limit) begin
            if (cnt_q == RING_FULL) begin
              full_d = 1'b1;
            end else begin
              wr_en  = 1'b1;
              cnt_d  = cnt_q + CNT_W'(1);
              sum_d  = sum_q + {1'b0, len_q};
              pass_d = 1'b1;
            end
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Ring memory port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= {now_q, len_q};
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_pass_q <= '0;
      oldest_q    <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_pass_q <= last_pass_d;
      oldest_q    <= oldest_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      min_period_q <= '0;
      byte_limit_q <= '0;
      window_q     <= mrbwt_pkg::WINDOW_TICKS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mrbwt_pkg::REG_MESSAGE_MODE: mode_q       <= cfg_data_i[0];
        mrbwt_pkg::REG_MIN_PERIOD:   min_period_q <= cfg_data_i[TIME_W-1:0];
        mrbwt_pkg::REG_BYTE_LIMIT:   byte_limit_q <= cfg_data_i[LEN_W-1:0];
        mrbwt_pkg::REG_WINDOW_TICKS: window_q     <= cfg_data_i[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Item capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q <= now_ticks_i;
      len_q <= message_bytes_i;
    end
    pass_q  <= pass_d;
    full_q  <= full_d;
    bytes_q <= bytes_d;
  end

  assign out_valid_o       = out_valid_q;
  assign pass_o            = pass_q;
  assign ring_full_drop_o  = full_q;
  assign bytes_in_window_o = bytes_q;

  // Checks
  `MRBWT_ASSERT(a_cnt_range, 1'b1, cnt_q <= RING_FULL, "ring count above depth")
  `MRBWT_ASSERT(a_empty_sum, cnt_q == '0, sum_q == '0, "window sum nonzero on empty ring")
  `MRBWT_ASSERT(a_pass_full, out_valid_q, !(pass_q && full_q), "pass with ring-full drop")
  `MRBWT_ASSERT_NEXT(a_pop_cnt, (state_q == S_EXP) && expire,
                     cnt_q == $past(cnt_q) - CNT_W'(1), "retire did not drop count")

endmodule
